/* hw/rtl/fisheye_equisolid_texcoord_map_top_macros.svh */
// ----------------------------------------------------------------------------
// Equisolid fisheye texcoord map - assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef FISHEYE_EQUISOLID_TEXCOORD_MAP_TOP_MACROS_SVH
`define FISHEYE_EQUISOLID_TEXCOORD_MAP_TOP_MACROS_SVH

// property checked only outside reset
`define FET_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define FET_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hw/rtl/fet_pkg.sv */
// ----------------------------------------------------------------------------
// fet_pkg
// Constants shared by the fisheye texcoord mapper and its checker.
// ----------------------------------------------------------------------------
package fet_pkg;

    localparam int ZW = 48;

    // angle bounds in 1/256 degree
    localparam logic signed [17:0] ANG_QUARTER = 18'sd23040;
    localparam logic signed [17:0] ANG_HALF    = 18'sd46080;
    localparam logic signed [17:0] ANG_FULL    = 18'sd92160;

    // 1/256 degree in 1e-12 degree units
    localparam logic signed [ZW-1:0] ANG_UNIT = 48'sd3906250000;

    localparam logic [16:0] OUT_MAX = 17'd65536;
    localparam logic [16:0] OUT_CENTER = 17'd32768;

    localparam logic signed [ZW-1:0] ATAN_TAB [0:16] = '{
        48'sd45000000000000, 48'sd26565051177078, 48'sd14036243467926,
        48'sd7125016348902,  48'sd3576334374997,  48'sd1789910608246,
        48'sd895173710211,   48'sd447614170861,   48'sd223810500369,
        48'sd111905677066,   48'sd55952891894,    48'sd27976452617,
        48'sd13988227142,    48'sd6994113675,     48'sd3497056851,
        48'sd1748528427,     48'sd874264214
    };

    function automatic logic signed [ZW-1:0] atan_step(input int i);
        logic [63:0] tail;
        tail = 64'd57295779513082 >> i;
        if (i < 17) begin
            return ATAN_TAB[i];
        end
        return ZW'(tail);
    endfunction

endpackage

/* hw/rtl/fisheye_equisolid_texcoord_map_top.sv */
// ----------------------------------------------------------------------------
// fisheye_equisolid_texcoord_map_top
// Latitude/longitude to equisolid fisheye texture coordinate, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_lat_angle / i_lon_angle with start high; the
//   transaction is taken at any edge where start is high and busy is low.
//   busy is held low: a new transaction may enter every cycle.
//   Result channel: o_valid strobes for one cycle with o_tex_s / o_tex_t.
//   The receiver cannot stall; every result must be taken when shown.
//   The pipeline holds one stage per CORDIC rotation, one per root bit
//   of the three square roots (two run side by side) and one per
//   quotient bit.
//   Throughput: one transaction per cycle.
//   Reset (synchronous, active low) clears every stage valid; items in
//   flight are dropped and no result is shown for them.
// ----------------------------------------------------------------------------
module fisheye_equisolid_texcoord_map_top
    import fet_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 18
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_lat_angle,
    input  logic        [16:0] i_lon_angle,
    output logic               o_valid,
    output logic        [16:0] o_tex_s,
    output logic        [16:0] o_tex_t
);

    localparam int F   = FRAC_BITS;
    localparam int N   = CORDIC_STEPS;
    localparam int W   = F + 3;
    localparam int SQW = 2 * F + 4;
    localparam int RW  = F + 2;
    localparam int NW  = 2 * F + 3;
    localparam int QB  = F + 1;
    localparam int OW  = W + 18;
    localparam int SHR = (F >= 16) ? F - 16 : 0;
    localparam int SHL = (F < 16) ? 16 - F : 0;

    localparam logic [63:0] XINIT64 = (64'd652032874 + (64'd1 << (29 - F))) >> (30 - F);
    localparam logic signed [W-1:0]  XINIT = W'(XINIT64);
    localparam logic [SQW-1:0]       FULL  = SQW'(1) << (2 * F);
    localparam logic [RW-1:0]        ONE_R = RW'(1) << F;
    localparam logic signed [W:0]    HALF  = (W + 1)'(1) << (F - 1);
    localparam logic signed [OW-1:0] RND   = (OW'(1) << SHR) >>> 1;

    function automatic logic [SQW+RW-1:0] sqrt_step(input logic [SQW-1:0] rem,
                                                    input logic [RW-1:0] root,
                                                    input int j);
        logic [SQW:0] t;
        t = ({1'b0, SQW'(root)} << (j + 1)) + ((SQW + 1)'(1) << (2 * j));
        if ({1'b0, rem} >= t) begin
            return {rem - SQW'(t), root | (RW'(1) << j)};
        end
        return {rem, root};
    endfunction

    function automatic logic [NW+QB-1:0] div_step(input logic [NW-1:0] rem,
                                                  input logic [QB-1:0] q,
                                                  input logic [NW-1:0] dv,
                                                  input int j);
        logic [NW-1:0] dj;
        dj = dv << j;
        if (rem >= dj) begin
            return {rem - dj, q | (QB'(1) << j)};
        end
        return {rem, q};
    endfunction

    function automatic logic [16:0] to_out(input logic signed [W:0] v);
        logic signed [OW-1:0] e;
        e = ((OW'(v) + RND) >>> SHR) <<< SHL;
        if (e < 0) begin
            return 17'd0;
        end
        if (e > $signed(OW'(OUT_MAX))) begin
            return OUT_MAX;
        end
        return e[16:0];
    endfunction

    assign busy = 1'b0;

    // ---------------- stage 1: wrap and fold ----------------
    logic signed [17:0] lat_ext, lon_ext, lon_w, n_lat, n_lon;
    logic               n_lat_neg, n_lon_neg;

    always_comb begin
        lat_ext = $signed({{2{i_lat_angle[15]}}, i_lat_angle});
        lon_ext = $signed({1'b0, i_lon_angle});
        lon_w   = (lon_ext > ANG_HALF) ? lon_ext - ANG_FULL : lon_ext;
        n_lat     = lat_ext;
        n_lat_neg = 1'b0;
        if (lat_ext > ANG_QUARTER) begin
            n_lat     = lat_ext - ANG_HALF;
            n_lat_neg = 1'b1;
        end else if (lat_ext < -ANG_QUARTER) begin
            n_lat     = lat_ext + ANG_HALF;
            n_lat_neg = 1'b1;
        end
        n_lon     = lon_w;
        n_lon_neg = 1'b0;
        if (lon_w > ANG_QUARTER) begin
            n_lon     = lon_w - ANG_HALF;
            n_lon_neg = 1'b1;
        end else if (lon_w < -ANG_QUARTER) begin
            n_lon     = lon_w + ANG_HALF;
            n_lon_neg = 1'b1;
        end
    end

    logic               r_s1_vld, r_s1_lat_neg, r_s1_lon_neg;
    logic signed [17:0] r_s1_lat, r_s1_lon;
    logic               r_s2_vld, r_s2_lat_neg, r_s2_lon_neg;
    logic signed [ZW-1:0] r_s2_zlat, r_s2_zlon;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
            r_s2_vld <= r_s1_vld;
        end
        r_s1_lat     <= n_lat;
        r_s1_lon     <= n_lon;
        r_s1_lat_neg <= n_lat_neg;
        r_s1_lon_neg <= n_lon_neg;
        r_s2_zlat    <= ZW'(r_s1_lat) * ANG_UNIT;
        r_s2_zlon    <= ZW'(r_s1_lon) * ANG_UNIT;
        r_s2_lat_neg <= r_s1_lat_neg;
        r_s2_lon_neg <= r_s1_lon_neg;
    end

    // ---------------- CORDIC rotations ----------------
    logic                 r_c_vld     [1:N];
    logic                 r_c_lat_neg [1:N];
    logic                 r_c_lon_neg [1:N];
    logic signed [W-1:0]  r_c_xa [1:N];
    logic signed [W-1:0]  r_c_ya [1:N];
    logic signed [ZW-1:0] r_c_za [1:N];
    logic signed [W-1:0]  r_c_xo [1:N];
    logic signed [W-1:0]  r_c_yo [1:N];
    logic signed [ZW-1:0] r_c_zo [1:N];

    for (genvar k = 0; k < N; k++) begin : g_cordic
        localparam logic signed [ZW-1:0] ATN = atan_step(k);
        logic                 vin, lan, lon;
        logic signed [W-1:0]  xa, ya, xo, yo;
        logic signed [ZW-1:0] za, zo;
        if (k == 0) begin : g_first
            assign vin = r_s2_vld;
            assign lan = r_s2_lat_neg;
            assign lon = r_s2_lon_neg;
            assign xa  = XINIT;
            assign ya  = '0;
            assign za  = r_s2_zlat;
            assign xo  = XINIT;
            assign yo  = '0;
            assign zo  = r_s2_zlon;
        end else begin : g_next
            assign vin = r_c_vld[k];
            assign lan = r_c_lat_neg[k];
            assign lon = r_c_lon_neg[k];
            assign xa  = r_c_xa[k];
            assign ya  = r_c_ya[k];
            assign za  = r_c_za[k];
            assign xo  = r_c_xo[k];
            assign yo  = r_c_yo[k];
            assign zo  = r_c_zo[k];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c_vld[k+1] <= 1'b0;
            end else begin
                r_c_vld[k+1] <= vin;
            end
            r_c_lat_neg[k+1] <= lan;
            r_c_lon_neg[k+1] <= lon;
            if (!za[ZW-1]) begin
                r_c_xa[k+1] <= xa - (ya >>> k);
                r_c_ya[k+1] <= ya + (xa >>> k);
                r_c_za[k+1] <= za - ATN;
            end else begin
                r_c_xa[k+1] <= xa + (ya >>> k);
                r_c_ya[k+1] <= ya - (xa >>> k);
                r_c_za[k+1] <= za + ATN;
            end
            if (!zo[ZW-1]) begin
                r_c_xo[k+1] <= xo - (yo >>> k);
                r_c_yo[k+1] <= yo + (xo >>> k);
                r_c_zo[k+1] <= zo - ATN;
            end else begin
                r_c_xo[k+1] <= xo + (yo >>> k);
                r_c_yo[k+1] <= yo - (xo >>> k);
                r_c_zo[k+1] <= zo + ATN;
            end
        end
    end

    // ---------------- px, s^2 ----------------
    logic                r_s3_vld, r_s4_vld, r_s5_vld, r_s6_vld, r_s7_vld;
    logic signed [W-1:0] r_s3_cu, r_s3_su, r_s3_cv;
    logic signed [W-1:0] r_s4_px, r_s4_py, r_s5_px, r_s5_py, r_s6_px, r_s6_py;
    logic signed [W-1:0] r_s7_px, r_s7_py;
    logic [2*W-1:0]      r_s5_px2, r_s5_py2;
    logic [SQW-1:0]      r_s6_s2, r_s7_sn, r_s7_cn;
    logic                r_s7_zero;
    logic signed [2*W-1:0] prod_cc, sq_x, sq_y;
    logic [2*W-1:0]      sum_sq;

    assign prod_cc = r_s3_cu * r_s3_cv;
    assign sq_x    = r_s4_px * r_s4_px;
    assign sq_y    = r_s4_py * r_s4_py;
    assign sum_sq  = r_s5_px2 + r_s5_py2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
            r_s6_vld <= 1'b0;
            r_s7_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_c_vld[N];
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld;
            r_s6_vld <= r_s5_vld;
            r_s7_vld <= r_s6_vld;
        end
        r_s3_cu  <= r_c_lat_neg[N] ? -r_c_xa[N] : r_c_xa[N];
        r_s3_su  <= r_c_lat_neg[N] ? -r_c_ya[N] : r_c_ya[N];
        r_s3_cv  <= r_c_lon_neg[N] ? -r_c_xo[N] : r_c_xo[N];
        r_s4_px  <= W'(prod_cc >>> F);
        r_s4_py  <= r_s3_su;
        r_s5_px2 <= $unsigned(sq_x);
        r_s5_py2 <= $unsigned(sq_y);
        r_s5_px  <= r_s4_px;
        r_s5_py  <= r_s4_py;
        r_s6_s2  <= SQW'(sum_sq);
        r_s6_px  <= r_s5_px;
        r_s6_py  <= r_s5_py;
        r_s7_sn  <= r_s6_s2;
        r_s7_cn  <= (r_s6_s2 >= FULL) ? '0 : FULL - r_s6_s2;
        r_s7_zero <= (r_s6_s2 == '0);
        r_s7_px  <= r_s6_px;
        r_s7_py  <= r_s6_py;
    end

    // ---------------- s = sqrt(s2), c = sqrt(1 - s2) ----------------
    logic                r_q1_vld    [1:RW];
    logic                r_q1_zero   [1:RW];
    logic signed [W-1:0] r_q1_px     [1:RW];
    logic signed [W-1:0] r_q1_py     [1:RW];
    logic [SQW-1:0]      r_q1_rem_s  [1:RW];
    logic [RW-1:0]       r_q1_root_s [1:RW];
    logic [SQW-1:0]      r_q1_rem_c  [1:RW];
    logic [RW-1:0]       r_q1_root_c [1:RW];

    for (genvar k = 0; k < RW; k++) begin : g_sqrt1
        logic                vin, zin;
        logic signed [W-1:0] pxi, pyi;
        logic [SQW-1:0]      rs, rc;
        logic [RW-1:0]       qs, qc;
        if (k == 0) begin : g_first
            assign vin = r_s7_vld;
            assign zin = r_s7_zero;
            assign pxi = r_s7_px;
            assign pyi = r_s7_py;
            assign rs  = r_s7_sn;
            assign qs  = '0;
            assign rc  = r_s7_cn;
            assign qc  = '0;
        end else begin : g_next
            assign vin = r_q1_vld[k];
            assign zin = r_q1_zero[k];
            assign pxi = r_q1_px[k];
            assign pyi = r_q1_py[k];
            assign rs  = r_q1_rem_s[k];
            assign qs  = r_q1_root_s[k];
            assign rc  = r_q1_rem_c[k];
            assign qc  = r_q1_root_c[k];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_q1_vld[k+1] <= 1'b0;
            end else begin
                r_q1_vld[k+1] <= vin;
            end
            r_q1_zero[k+1] <= zin;
            r_q1_px[k+1]   <= pxi;
            r_q1_py[k+1]   <= pyi;
            {r_q1_rem_s[k+1], r_q1_root_s[k+1]} <= sqrt_step(rs, qs, RW - 1 - k);
            {r_q1_rem_c[k+1], r_q1_root_c[k+1]} <= sqrt_step(rc, qc, RW - 1 - k);
        end
    end

    // ---------------- m = sqrt((1 - c) << F) ----------------
    logic                r_s8_vld, r_s8_zero;
    logic signed [W-1:0] r_s8_px, r_s8_py;
    logic [RW-1:0]       r_s8_s, d_val;
    logic [SQW-1:0]      r_s8_mn;

    assign d_val = (r_q1_root_c[RW] > ONE_R) ? '0 : ONE_R - r_q1_root_c[RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_vld <= 1'b0;
        end else begin
            r_s8_vld <= r_q1_vld[RW];
        end
        r_s8_zero <= r_q1_zero[RW];
        r_s8_px   <= r_q1_px[RW];
        r_s8_py   <= r_q1_py[RW];
        r_s8_s    <= r_q1_root_s[RW];
        r_s8_mn   <= SQW'(d_val) << F;
    end

    logic                r_q2_vld  [1:RW];
    logic                r_q2_zero [1:RW];
    logic signed [W-1:0] r_q2_px   [1:RW];
    logic signed [W-1:0] r_q2_py   [1:RW];
    logic [RW-1:0]       r_q2_s    [1:RW];
    logic [SQW-1:0]      r_q2_rem  [1:RW];
    logic [RW-1:0]       r_q2_root [1:RW];

    for (genvar k = 0; k < RW; k++) begin : g_sqrt2
        logic                vin, zin;
        logic signed [W-1:0] pxi, pyi;
        logic [RW-1:0]       si, qi;
        logic [SQW-1:0]      ri;
        if (k == 0) begin : g_first
            assign vin = r_s8_vld;
            assign zin = r_s8_zero;
            assign pxi = r_s8_px;
            assign pyi = r_s8_py;
            assign si  = r_s8_s;
            assign ri  = r_s8_mn;
            assign qi  = '0;
        end else begin : g_next
            assign vin = r_q2_vld[k];
            assign zin = r_q2_zero[k];
            assign pxi = r_q2_px[k];
            assign pyi = r_q2_py[k];
            assign si  = r_q2_s[k];
            assign ri  = r_q2_rem[k];
            assign qi  = r_q2_root[k];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_q2_vld[k+1] <= 1'b0;
            end else begin
                r_q2_vld[k+1] <= vin;
            end
            r_q2_zero[k+1] <= zin;
            r_q2_px[k+1]   <= pxi;
            r_q2_py[k+1]   <= pyi;
            r_q2_s[k+1]    <= si;
            {r_q2_rem[k+1], r_q2_root[k+1]} <= sqrt_step(ri, qi, RW - 1 - k);
        end
    end

    // ---------------- |p| * m / (2 s) ----------------
    logic           r_s9_vld, r_s9_zero, r_s9_sx, r_s9_sy;
    logic [NW-1:0]  r_s9_nx, r_s9_ny, r_s9_dv;
    logic [W-1:0]   apx, apy;

    assign apx = r_q2_px[RW][W-1] ? $unsigned(-r_q2_px[RW]) : $unsigned(r_q2_px[RW]);
    assign apy = r_q2_py[RW][W-1] ? $unsigned(-r_q2_py[RW]) : $unsigned(r_q2_py[RW]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s9_vld <= 1'b0;
        end else begin
            r_s9_vld <= r_q2_vld[RW];
        end
        r_s9_zero <= r_q2_zero[RW];
        r_s9_sx   <= r_q2_px[RW][W-1];
        r_s9_sy   <= r_q2_py[RW][W-1];
        r_s9_nx   <= NW'(apx) * NW'(r_q2_root[RW]);
        r_s9_ny   <= NW'(apy) * NW'(r_q2_root[RW]);
        r_s9_dv   <= NW'({r_q2_s[RW], 1'b0});
    end

    logic          r_d_vld  [1:QB];
    logic          r_d_zero [1:QB];
    logic          r_d_sx   [1:QB];
    logic          r_d_sy   [1:QB];
    logic [NW-1:0] r_d_dv   [1:QB];
    logic [NW-1:0] r_d_rx   [1:QB];
    logic [NW-1:0] r_d_ry   [1:QB];
    logic [QB-1:0] r_d_qx   [1:QB];
    logic [QB-1:0] r_d_qy   [1:QB];

    for (genvar k = 0; k < QB; k++) begin : g_div
        logic          vin, zin, sxi, syi;
        logic [NW-1:0] dvi, rxi, ryi;
        logic [QB-1:0] qxi, qyi;
        if (k == 0) begin : g_first
            assign vin = r_s9_vld;
            assign zin = r_s9_zero;
            assign sxi = r_s9_sx;
            assign syi = r_s9_sy;
            assign dvi = r_s9_dv;
            assign rxi = r_s9_nx;
            assign ryi = r_s9_ny;
            assign qxi = '0;
            assign qyi = '0;
        end else begin : g_next
            assign vin = r_d_vld[k];
            assign zin = r_d_zero[k];
            assign sxi = r_d_sx[k];
            assign syi = r_d_sy[k];
            assign dvi = r_d_dv[k];
            assign rxi = r_d_rx[k];
            assign ryi = r_d_ry[k];
            assign qxi = r_d_qx[k];
            assign qyi = r_d_qy[k];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_vld[k+1] <= 1'b0;
            end else begin
                r_d_vld[k+1] <= vin;
            end
            r_d_zero[k+1] <= zin;
            r_d_sx[k+1]   <= sxi;
            r_d_sy[k+1]   <= syi;
            r_d_dv[k+1]   <= dvi;
            {r_d_rx[k+1], r_d_qx[k+1]} <= div_step(rxi, qxi, dvi, QB - 1 - k);
            {r_d_ry[k+1], r_d_qy[k+1]} <= div_step(ryi, qyi, dvi, QB - 1 - k);
        end
    end

    // ---------------- output ----------------
    logic signed [W:0] ox, oy, vs, vt;
    logic              r_vld;
    logic [16:0]       r_tex_s, r_tex_t;

    assign ox = r_d_sx[QB] ? -$signed((W + 1)'(r_d_qx[QB])) : $signed((W + 1)'(r_d_qx[QB]));
    assign oy = r_d_sy[QB] ? -$signed((W + 1)'(r_d_qy[QB])) : $signed((W + 1)'(r_d_qy[QB]));
    assign vs = HALF + ox;
    assign vt = HALF - oy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= r_d_vld[QB];
        end
        r_tex_s <= r_d_zero[QB] ? OUT_CENTER : to_out(vs);
        r_tex_t <= r_d_zero[QB] ? OUT_CENTER : to_out(vt);
    end

    assign o_valid = r_vld;
    assign o_tex_s = r_tex_s;
    assign o_tex_t = r_tex_t;

endmodule

/* hw/rtl/fet_checker.sv */
// ----------------------------------------------------------------------------
// fet_checker
// Port-level checks for the fisheye texcoord mapper, bound to the top level.
// ----------------------------------------------------------------------------
`include "fisheye_equisolid_texcoord_map_top_macros.svh"

module fet_checker
    import fet_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 18
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [16:0] o_tex_s,
    input logic [16:0] o_tex_t
);

    localparam int LAT = CORDIC_STEPS + 3 * FRAC_BITS + 15;

    `FET_ASSERT_ALL(a_rst_clears_valid, !i_rst_n |=> !o_valid, "result strobe after reset")
    `FET_ASSERT_RUN(a_valid_has_cmd, o_valid |-> $past(start, LAT), "result without transaction")
    `FET_ASSERT_RUN(a_tex_s_range, o_valid |-> (o_tex_s <= OUT_MAX), "tex_s out of range")
    `FET_ASSERT_RUN(a_tex_t_range, o_valid |-> (o_tex_t <= OUT_MAX), "tex_t out of range")
    `FET_ASSERT_RUN(a_never_busy, start |-> !busy, "transaction refused")

endmodule

bind fisheye_equisolid_texcoord_map_top fet_checker #(
    .FRAC_BITS   (FRAC_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
) u_fet_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .start  (start),
    .busy   (busy),
    .o_valid(o_valid),
    .o_tex_s(o_tex_s),
    .o_tex_t(o_tex_t)
);

/* tb/sv/fisheye_equisolid_texcoord_map_top_tb.sv */
// ----------------------------------------------------------------------------
// fisheye_equisolid_texcoord_map_top_tb
// Drives latitude/longitude transactions in random bursts, predicts every
// texture coordinate with a bit-exact fixed-point CORDIC/isqrt model and
// compares each strobed result with the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module fisheye_equisolid_texcoord_map_top_tb
    import fet_pkg::*;
();

    localparam int  FRAC    = 16;
    localparam int  STEPS   = 18;
    localparam int  LATENCY = STEPS + 3 * FRAC + 15;
    localparam longint DEG90  = 64'sd90000000000000;
    localparam longint DEG180 = 64'sd180000000000000;
    localparam longint DEG360 = 64'sd360000000000000;

    typedef struct packed {
        logic [16:0] tex_s;
        logic [16:0] tex_t;
    } t_texcoord;

    class t_texcoord_scoreboard;
        t_texcoord expected_q[$];
        int errors;

        function automatic longint unsigned int_sqrt(input longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function automatic longint rot_angle(input int i);
            if (i < 17) return longint'(ATAN_TAB[i]);
            return longint'(64'd57295779513082 >> i);
        endfunction

        function automatic void sin_cos(input longint a, output longint cs, output longint sn);
            longint x, y, z, dx, dy;
            bit flip;
            flip = 0;
            while (a > DEG180) a = a - DEG360;
            while (a <= -DEG180) a = a + DEG360;
            if (a > DEG90) begin
                a = a - DEG180;
                flip = 1;
            end else if (a < -DEG90) begin
                a = a + DEG180;
                flip = 1;
            end
            x = (64'sd652032874 + (64'sd1 << (29 - FRAC))) >>> (30 - FRAC);
            y = 0;
            z = a;
            for (int i = 0; i < STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - rot_angle(i);
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + rot_angle(i);
                end
            end
            cs = flip ? -x : x;
            sn = flip ? -y : y;
        endfunction

        function automatic longint offset_div(input longint p, input longint m, input longint s);
            longint unsigned mag;
            mag = longint'(p < 0 ? -p : p) * longint'(m) / (2 * longint'(s));
            return p < 0 ? -longint'(mag) : longint'(mag);
        endfunction

        function automatic logic [16:0] to_q16(input longint v);
            longint r;
            r = (v + ((64'sd1 << (FRAC - 16)) >>> 1)) >>> (FRAC - 16);
            if (r < 0) r = 0;
            if (r > 65536) r = 65536;
            return r[16:0];
        endfunction

        function automatic t_texcoord equisolid_map(input logic signed [15:0] lat,
                                                    input logic [16:0] lon);
            longint one, cu, su, cv, sv, px, py, s, c, d, m;
            longint unsigned s2, full;
            t_texcoord r;
            one = 64'sd1 << FRAC;
            sin_cos(longint'(lat) * 64'sd3906250000, cu, su);
            sin_cos(longint'({1'b0, lon}) * 64'sd3906250000, cv, sv);
            px = (cu * cv) >>> FRAC;
            py = su;
            s2 = px * px + py * py;
            if (s2 == 0) begin
                r.tex_s = to_q16(one >>> 1);
                r.tex_t = r.tex_s;
                return r;
            end
            full = 64'd1 << (2 * FRAC);
            s = int_sqrt(s2);
            c = int_sqrt(s2 >= full ? 0 : full - s2);
            d = one - c;
            if (d < 0) d = 0;
            m = int_sqrt(d << FRAC);
            r.tex_s = to_q16((one >>> 1) + offset_div(px, m, s));
            r.tex_t = to_q16((one >>> 1) - offset_div(py, m, s));
            return r;
        endfunction

        function void note_command(input logic signed [15:0] lat, input logic [16:0] lon);
            expected_q.push_back(equisolid_map(lat, lon));
        endfunction

        task report(input string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(input logic [16:0] s, input logic [16:0] t);
            t_texcoord e;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result s=%0d t=%0d", s, t));
                return;
            end
            e = expected_q.pop_front();
            if (s !== e.tex_s)
                report($sformatf("tex_s got %0d expected %0d", s, e.tex_s));
            if (t !== e.tex_t)
                report($sformatf("tex_t got %0d expected %0d", t, e.tex_t));
        endtask
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               start = 0;
    logic               busy;
    logic signed [15:0] i_lat_angle = '0;
    logic        [16:0] i_lon_angle = '0;
    logic               o_valid;
    logic        [16:0] o_tex_s, o_tex_t;

    t_texcoord_scoreboard sb = new();
    int burst_left = 0;

    fisheye_equisolid_texcoord_map_top #(.FRAC_BITS(FRAC), .CORDIC_STEPS(STEPS)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_lat_angle(i_lat_angle), .i_lon_angle(i_lon_angle),
        .o_valid(o_valid), .o_tex_s(o_tex_s), .o_tex_t(o_tex_t)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_tex_s, o_tex_t);
    end

    // one transaction; idle gap taken between bursts
    task send_command(input logic signed [15:0] lat, input logic [16:0] lon);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                start <= 1'b0;
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        @(negedge i_clk);
        start       <= 1'b1;
        i_lat_angle <= lat;
        i_lon_angle <= lon;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_command(lat, lon);
    endtask

    task random_command();
        logic signed [15:0] lat;
        logic [16:0] lon;
        if ($urandom_range(0, 9) < 8) begin
            lat = $signed(16'($urandom_range(0, 46080))) - 16'sd23040;
            lon = 17'($urandom_range(0, 92159));
        end else begin
            lat = 16'($urandom);
            lon = 17'($urandom);
        end
        send_command(lat, lon);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_command(16'sd0, 17'd23040);
        send_command(-16'sd23040, 17'd0);
        send_command(16'sd23040, 17'd0);
        send_command(16'sd0, 17'd0);
        send_command(16'sd0, 17'd92159);
        send_command(16'sd0, 17'd46080);
        send_command(16'sd0, 17'd69120);
        send_command(16'sd11520, 17'd11520);
        send_command(-16'sd11520, 17'd80640);
        send_command(-16'sd32768, 17'd131071);
        send_command(16'sd32767, 17'd92160);
        send_command(16'sd256, 17'd23040);
        send_command(16'sd1, 17'd23040);
        send_command(-16'sd1, 17'd23039);
        send_command(16'sd23040, 17'd23040);
        send_command(-16'sd23040, 17'd46080);
        send_command(16'sd0, 17'd115200);

        for (int n = 0; n < 600; n++) begin
            random_command();
            if (n == 300) begin
                @(negedge i_clk);
                start <= 1'b0;
                while (sb.expected_q.size() != 0) @(posedge i_clk);
            end
        end
        @(negedge i_clk);
        start <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (sb.expected_q.size() != 0) sb.report("result never arrived");
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
